[rtl/core/cms_pkg.sv]
package cms_pkg;

   localparam int RowIdxWidth = 4;
   localparam int CfgIdxWidth = 3;
   localparam int CfgDataWidth = 64;

   localparam logic [CfgIdxWidth-1:0] CSR_ROW_COUNT = 3'd0;
   localparam logic [CfgIdxWidth-1:0] CSR_COLUMN_COUNT = 3'd1;
   localparam logic [CfgIdxWidth-1:0] CSR_KEY_LENGTH = 3'd2;
   localparam logic [CfgIdxWidth-1:0] CSR_SHIFT_A = 3'd3;
   localparam logic [CfgIdxWidth-1:0] CSR_SHIFT_B = 3'd4;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] hash;
      logic [15:0] cols;
   } mod_req_type;

   function automatic logic [31:0] mix_byte(logic [31:0] h_in, logic [7:0] k,
                                            logic [4:0] a, logic [4:0] b);
      logic [31:0] h;
      h = h_in + {24'd0, k};
      h = h + (h << a);
      h = h ^ (h >> b);
      return h;
   endfunction

   function automatic logic [31:0] mix_final(logic [31:0] h_in, logic [7:0] a,
                                             logic [7:0] b);
      logic [31:0] h;
      logic [7:0]  ba;
      logic [7:0]  ab;
      logic [7:0]  s;
      ba = b - a;
      ab = a - b;
      s = a + b;
      h = h_in + (h_in << ba[4:0]);
      h = h ^ (h >> ab[4:0]);
      h = h + (h << s[4:0]);
      return h;
   endfunction

endpackage

[rtl/core/count_min_sketch_top.sv]
// channel  ports                                 direction
// req      start, busy, req_opcode, req_key_value in (busy out)
// rsp      rsp_valid, rsp_estimate              out, one-cycle strobe
// csr      csr_write, csr_index, csr_data       in, no wait
// Update: per row one hash step per key byte, a finishing step, a serial modulo
// by the column count, a read and a write, bounded by the serial remainder unit
// and the registered counter memory read; busy stays high until the last row is
// done. Query takes the same and strobes the estimate in the cycle after its last row.
// After reset a clearing pass zeroes all MAX_ROWS*MAX_COLUMNS counters; busy stays
// high meanwhile. The receiver cannot stall: the estimate shows for one cycle.
module count_min_sketch_top #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_KEY_BYTES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic [63:0]                       req_key_value,
   output logic                              rsp_valid,
   output logic [31:0]                       rsp_estimate,
   input  logic                              csr_write,
   input  logic [cms_pkg::CfgIdxWidth-1:0]   csr_index,
   input  logic [cms_pkg::CfgDataWidth-1:0]  csr_data
);
   import cms_pkg::*;

   localparam int ColW = $clog2(MAX_COLUMNS);
   localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int Depth = MAX_ROWS * MAX_COLUMNS;
   localparam int AddrW = $clog2(Depth);

   logic [3:0]  row_count_ff;
   logic [10:0] column_count_ff;
   logic [3:0]  key_length_ff;
   logic [63:0] shift_a_ff;
   logic [63:0] shift_b_ff;

   state_type   state_ff, state_in;
   logic        op_ff, op_in;
   logic [63:0] key_ff, key_in;
   logic [4:0]  row_ff, row_in;
   logic [3:0]  byte_ff, byte_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] best_ff, best_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [AddrW:0] clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [4:0]  rows_eff;
   logic [15:0] cols_eff;
   logic [3:0]  klen_eff;
   logic [7:0]  coef_a, coef_b;
   mod_req_type mod_req;
   logic        mod_done;
   logic [15:0] mod_rem;
   logic        wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;

   always_comb begin
      if (row_count_ff == 4'd0) rows_eff = 5'd1;
      else if ({1'b0, row_count_ff} > 5'(MAX_ROWS)) rows_eff = 5'(MAX_ROWS);
      else rows_eff = {1'b0, row_count_ff};
      if (column_count_ff == 11'd0) cols_eff = 16'd1;
      else if ({5'd0, column_count_ff} > 16'(MAX_COLUMNS)) cols_eff = 16'(MAX_COLUMNS);
      else cols_eff = {5'd0, column_count_ff};
      if (key_length_ff > 4'(MAX_KEY_BYTES)) klen_eff = 4'(MAX_KEY_BYTES);
      else klen_eff = key_length_ff;
      if (row_ff < 5'd8) begin
         coef_a = shift_a_ff[row_ff[2:0]*8 +: 8];
         coef_b = shift_b_ff[row_ff[2:0]*8 +: 8];
      end else begin
         coef_a = 8'd0;
         coef_b = 8'd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      row_in = row_ff;
      byte_in = byte_ff;
      hash_in = hash_ff;
      best_in = best_ff;
      addr_in = addr_ff;
      clr_in = clr_ff;
      rsp_valid_in = 1'b0;
      mod_req = '{start: 1'b0, hash: hash_ff, cols: cols_eff};
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = rd_data + 32'd1;
      rd_addr = addr_ff;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[AddrW-1:0];
            wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AddrW+1)'(Depth - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               op_in = req_opcode;
               key_in = req_key_value;
               row_in = 5'd0;
               byte_in = 4'd0;
               hash_in = '0;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (byte_ff < klen_eff) begin
               hash_in = mix_byte(hash_ff, key_ff[byte_ff[2:0]*8 +: 8],
                                  coef_a[4:0], coef_b[4:0]);
               byte_in = byte_ff + 4'd1;
            end else begin
               mod_req.start = 1'b1;
               mod_req.hash = mix_final(hash_ff, coef_a, coef_b);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               addr_in = AddrW'(row_ff[RowW-1:0]) * AddrW'(MAX_COLUMNS)
                       + AddrW'(mod_rem[ColW-1:0]);
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_WRITE;
         ST_WRITE: begin
            if (op_ff == OP_UPDATE) wr_en = 1'b1;
            else if (row_ff == 5'd0 || rd_data < best_ff) best_in = rd_data;
            if (row_ff + 5'd1 >= rows_eff) begin
               state_in = ST_IDLE;
               if (op_ff == OP_QUERY) begin
                  rsp_valid_in = 1'b1;
                  if (!(row_ff == 5'd0 || rd_data < best_ff)) best_in = best_ff;
               end
            end else begin
               row_in = row_ff + 5'd1;
               byte_in = 4'd0;
               hash_in = '0;
               state_in = ST_HASH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   cms_mod u_mod (
      .clock(clock), .reset(reset), .req(mod_req), .done(mod_done), .remainder(mod_rem)
   );

   cms_mem #(.Depth(Depth), .AddrWidth(AddrW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      key_ff <= key_in;
      byte_ff <= byte_in;
      hash_ff <= hash_in;
      best_ff <= best_in;
      addr_ff <= addr_in;
      row_ff <= row_in;
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         row_count_ff <= 4'd4;
         column_count_ff <= 11'd1024;
         key_length_ff <= 4'd4;
         shift_a_ff <= '0;
         shift_b_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_ROW_COUNT: row_count_ff <= csr_data[3:0];
               CSR_COLUMN_COUNT: column_count_ff <= csr_data[10:0];
               CSR_KEY_LENGTH: key_length_ff <= csr_data[3:0];
               CSR_SHIFT_A: shift_a_ff <= csr_data;
               CSR_SHIFT_B: shift_b_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_estimate = best_ff;

   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_WRITE && op_ff == OP_QUERY))
      else $error("response without query");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe too long");
   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> busy)
      else $error("accepting during clear");
endmodule

[rtl/core/cms_mod.sv]
module cms_mod (
   input  logic                clock,
   input  logic                reset,
   input  cms_pkg::mod_req_type req,
   output logic                done,
   output logic [15:0]         remainder
);
   import cms_pkg::*;

   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [16:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done = 1'b0;
      trial = {rem_ff[15:0], quot_ff[31]};
      if (req.start) begin
         quot_in = req.hash;
         rem_in = '0;
         div_in = req.cols;
         cnt_in = 6'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (cnt_ff == 6'd32) begin
            done = 1'b1;
            run_in = 1'b0;
            cnt_in = 6'd0;
         end else begin
            quot_in = {quot_ff[30:0], 1'b0};
            if (trial >= {1'b0, div_ff}) rem_in = trial - {1'b0, div_ff};
            else rem_in = trial;
            cnt_in = cnt_ff + 6'd1;
         end
      end
   end

   assign remainder = rem_ff[15:0];

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

[rtl/core/cms_mem.sv]
module cms_mem #(
   parameter int Depth = 8192,
   parameter int AddrWidth = 13
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [31:0]          wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [31:0]          rd_data
);
   logic [31:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[dv/tb_count_min_sketch_top.sv]
`timescale 1ns / 1ps

module tb_count_min_sketch_top;
   import cms_pkg::*;

   localparam int NumRows = 8;
   localparam int NumCols = 1024;
   localparam int CycleLimit = 3000000;
   localparam int DrainCycles = 500;

   typedef struct {
      logic        op;
      logic [63:0] key;
   } sketch_word_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_opcode;
   logic [63:0] req_key_value;
   logic rsp_valid;
   logic [31:0] rsp_estimate;
   logic csr_write;
   logic [CfgIdxWidth-1:0] csr_index;
   logic [CfgDataWidth-1:0] csr_data;

   sketch_word_type pending_words[$];
   logic [31:0] expected_estimates[$];
   logic [31:0] counter_image[NumRows*NumCols];
   logic [3:0] cfg_rows;
   logic [10:0] cfg_cols;
   logic [3:0] cfg_key_len;
   logic [63:0] cfg_a;
   logic [63:0] cfg_b;
   logic [63:0] key_pool[16];
   logic req_taken;
   int idle_pct;
   bit drain_mode;
   int error_count;
   int cycle_count;

   count_min_sketch_top i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_key_value(req_key_value),
      .rsp_valid(rsp_valid),
      .rsp_estimate(rsp_estimate),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] sketch_hash(logic [7:0] a, logic [7:0] b,
                                               logic [63:0] key, int n);
      logic [31:0] h;
      logic [7:0] ba;
      logic [7:0] ab;
      logic [7:0] s;
      h = '0;
      for (int i = 0; i < n; i++) begin
         h = h + {24'd0, key[8*i +: 8]};
         h = h + (h << a[4:0]);
         h = h ^ (h >> b[4:0]);
      end
      ba = b - a;
      ab = a - b;
      s = a + b;
      h = h + (h << ba[4:0]);
      h = h ^ (h >> ab[4:0]);
      h = h + (h << s[4:0]);
      return h;
   endfunction

   task automatic apply_word(sketch_word_type w);
      int rows;
      int cols;
      int klen;
      int idx;
      logic [31:0] best;
      rows = (cfg_rows == 0) ? 1 : (cfg_rows > NumRows) ? NumRows : cfg_rows;
      cols = (cfg_cols == 0) ? 1 : (cfg_cols > NumCols) ? NumCols : cfg_cols;
      klen = (cfg_key_len > 8) ? 8 : cfg_key_len;
      best = '0;
      for (int r = 0; r < rows; r++) begin
         idx = r * NumCols + int'(sketch_hash(cfg_a[8*r +: 8], cfg_b[8*r +: 8], w.key,
                                              klen) % cols);
         if (w.op == OP_UPDATE) begin
            counter_image[idx] = counter_image[idx] + 1;
         end else if (r == 0 || counter_image[idx] < best) begin
            best = counter_image[idx];
         end
      end
      if (w.op == OP_QUERY) expected_estimates.push_back(best);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR @%0t: %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         foreach (counter_image[i]) counter_image[i] = '0;
         cfg_rows = 4'd4;
         cfg_cols = 11'd1024;
         cfg_key_len = 4'd4;
         cfg_a = '0;
         cfg_b = '0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            if (expected_estimates.size() == 0) begin
               report_mismatch("unexpected estimate", rsp_estimate, '0);
            end else begin
               if (rsp_estimate !== expected_estimates[0])
                  report_mismatch("estimate", rsp_estimate, expected_estimates[0]);
               void'(expected_estimates.pop_front());
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_ROW_COUNT: cfg_rows = csr_data[3:0];
               CSR_COLUMN_COUNT: cfg_cols = csr_data[10:0];
               CSR_KEY_LENGTH: cfg_key_len = csr_data[3:0];
               CSR_SHIFT_A: cfg_a = csr_data;
               CSR_SHIFT_B: cfg_b = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) apply_word('{req_opcode, req_key_value});
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_opcode <= OP_UPDATE;
         req_key_value <= '0;
      end else if (!start || req_taken) begin
         if (pending_words.size() > 0 && !(drain_mode && expected_estimates.size() > 0)
             && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_opcode <= pending_words[0].op;
            req_key_value <= pending_words[0].key;
            void'(pending_words.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic settle();
      wait (pending_words.size() == 0 && !start);
      wait (expected_estimates.size() == 0);
      wait (!busy);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic configure(logic [3:0] rows, logic [10:0] cols, logic [3:0] klen,
                            logic [63:0] a, logic [63:0] b);
      write_reg(CSR_ROW_COUNT, {60'd0, rows});
      write_reg(CSR_COLUMN_COUNT, {53'd0, cols});
      write_reg(CSR_KEY_LENGTH, {60'd0, klen});
      write_reg(CSR_SHIFT_A, a);
      write_reg(CSR_SHIFT_B, b);
   endtask

   task automatic push_word(logic op, logic [63:0] key);
      pending_words.push_back('{op, key});
   endtask

   task automatic push_random(int count);
      logic [63:0] key;
      for (int i = 0; i < count; i++) begin
         key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(15)]
                                       : {$urandom, $urandom};
         push_word(($urandom_range(9) < 4) ? OP_QUERY : OP_UPDATE, key);
      end
   endtask

   initial begin
      logic [3:0] rows;
      logic [10:0] cols;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_pct = 0;
      drain_mode = 1'b0;
      error_count = 0;
      cycle_count = 0;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_word(OP_UPDATE, 64'd0);
      push_word(OP_UPDATE, '1);
      push_word(OP_UPDATE, 64'd0);
      push_word(OP_QUERY, 64'd0);
      push_word(OP_QUERY, '1);
      push_word(OP_QUERY, 64'h5555_5555_AAAA_AAAA);
      push_word(OP_UPDATE, 64'hAAAA_AAAA_5555_5555);
      push_word(OP_QUERY, 64'hAAAA_AAAA_5555_5555);
      settle();
      configure(4'd0, 11'd0, 4'd0, '1, '0);
      push_word(OP_UPDATE, 64'h0123_4567_89AB_CDEF);
      push_word(OP_UPDATE, '1);
      push_word(OP_QUERY, 64'd7);
      settle();
      configure(4'd15, 11'd2047, 4'd15, '1, {$urandom, $urandom});
      write_reg(3'd5, 64'd1);
      write_reg(3'd7, '1);
      push_word(OP_UPDATE, '1);
      push_word(OP_UPDATE, 64'd0);
      push_word(OP_UPDATE, '1);
      push_word(OP_QUERY, '1);
      push_word(OP_QUERY, 64'd0);
      push_word(OP_QUERY, 64'h8000_0000_0000_0001);
      settle();
      configure(4'd8, 11'd1024, 4'd8, '0, '1);
      push_word(OP_UPDATE, 64'h8000_0000_0000_0001);
      push_word(OP_QUERY, 64'h8000_0000_0000_0001);
      push_word(OP_QUERY, '1);

      for (int p = 0; p < 8; p++) begin
         settle();
         rows = 4'($urandom_range(8, 1));
         cols = (p == 1) ? 11'd1 : (p == 4) ? 11'd1024 : 11'($urandom_range(64, 2));
         if (p == 6) rows = 4'd8;
         configure(rows, cols, 4'($urandom_range(8, 0)),
                   (p == 3) ? '1 : {$urandom, $urandom},
                   (p == 5) ? '0 : {$urandom, $urandom});
         idle_pct = (p % 4 == 1) ? 71 : (p % 4 == 3) ? 34 : 0;
         drain_mode = (p == 2);
         push_random(130);
      end
      settle();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/cms_pkg.sv
rtl/core/cms_mod.sv
rtl/core/cms_mem.sv
rtl/core/count_min_sketch_top.sv
dv/tb_count_min_sketch_top.sv
